### src/pha_pkg.sv
// ----------------------------------------------------------------------------
// pha_pkg
// Shared types and codes for the pixel HSL adjust block.
// ----------------------------------------------------------------------------
package pha_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_HUE_OFFSET = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SAT_GAIN   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_LUM_GAIN   = 2'd2;

  localparam int CFG_W = 16;
  localparam logic [CFG_W-1:0] GAIN_UNITY = 16'd256;

  // hue segment of one output channel
  typedef enum logic [1:0] {
    SEG_RISE,
    SEG_HIGH,
    SEG_FALL,
    SEG_LOW
  } seg_t;

endpackage

### src/pha_div.sv
// ----------------------------------------------------------------------------
// pha_div
// Pipelined restoring divider, one quotient bit per stage. Computes
// floor(num * 2^FRAC_BITS / den) for num <= den, plus a remainder flag
// for ceiling rounding.
// ----------------------------------------------------------------------------
module pha_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk,
  input  logic [10:0]          num,
  input  logic [10:0]          den,
  output logic [FRAC_BITS:0]   quo,
  output logic                 rem_nz
);

  logic [11:0]        rem [0:FRAC_BITS];
  logic [10:0]        dsr [0:FRAC_BITS];
  logic [FRAC_BITS:0] qv  [0:FRAC_BITS];

  // integer bit
  always_ff @(posedge clk) begin
    dsr[0] <= den;
    if (num >= den) begin
      qv[0]  <= (FRAC_BITS+1)'(1);
      rem[0] <= {1'b0, num - den};
    end else begin
      qv[0]  <= '0;
      rem[0] <= {1'b0, num};
    end
  end

  // fraction bits
  for (genvar k = 1; k <= FRAC_BITS; k++) begin : g_step
    logic [11:0] shifted;
    logic        ge;
    assign shifted = {rem[k-1][10:0], 1'b0};
    assign ge      = shifted >= {1'b0, dsr[k-1]};
    always_ff @(posedge clk) begin
      dsr[k] <= dsr[k-1];
      qv[k]  <= {qv[k-1][FRAC_BITS-1:0], ge};
      rem[k] <= ge ? (shifted - {1'b0, dsr[k-1]}) : shifted;
    end
  end

  assign quo    = qv[FRAC_BITS];
  assign rem_nz = |rem[FRAC_BITS];

endmodule

### src/pixel_hsl_adjust.sv
// ----------------------------------------------------------------------------
// pixel_hsl_adjust
// Per-pixel hue / saturation / lightness adjustment of an 8-bit RGBA pixel.
//
//  channel   direction  handshake          payload
//  request   in         start / busy       in_red in_green in_blue in_alpha
//  result    out        done (one cycle)   out_red out_green out_blue out_alpha
//  config    in         cfg_we             cfg_index cfg_data
//
// One request per cycle; busy is always low. The path runs through the
// two bit-per-stage dividers (FRAC_BITS + 1 stages), which work side by
// side, plus ten stages of min/max, gain, RGB rebuild and byte scaling.
// rst (synchronous) clears the valid line and restores the registers.
// The receiver cannot stall: done pulses exactly once per request.
// ----------------------------------------------------------------------------
module pixel_hsl_adjust #(
  parameter int FRAC_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [7:0]  in_red,
  input  logic [7:0]  in_green,
  input  logic [7:0]  in_blue,
  input  logic [7:0]  in_alpha,
  output logic        done,
  output logic [7:0]  out_red,
  output logic [7:0]  out_green,
  output logic [7:0]  out_blue,
  output logic [7:0]  out_alpha,
  input  logic        cfg_we,
  input  logic [pha_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [pha_pkg::CFG_W-1:0]     cfg_data
);

  localparam int W   = FRAC_BITS + 1;
  localparam int SW  = W + 2;
  localparam logic [W-1:0] ONE   = W'(1) << FRAC_BITS;
  localparam logic [W-1:0] THIRD = W'((1 << FRAC_BITS) / 3);

  // configuration registers
  logic [15:0] hue_offset, sat_gain, lum_gain;

  always_ff @(posedge clk) begin
    if (rst) begin
      hue_offset <= '0;
      sat_gain   <= pha_pkg::GAIN_UNITY;
      lum_gain   <= pha_pkg::GAIN_UNITY;
    end else if (cfg_we) begin
      case (cfg_index)
        pha_pkg::CFG_HUE_OFFSET: hue_offset <= cfg_data;
        pha_pkg::CFG_SAT_GAIN:   sat_gain   <= cfg_data;
        pha_pkg::CFG_LUM_GAIN:   lum_gain   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // stage 1: max, min and divider operands
  logic [7:0]  mx, mn, dd;
  logic [8:0]  sm;
  logic [10:0] den_c, num_c;

  always_comb begin
    mx = in_red;
    mn = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue  > mx) mx = in_blue;
    if (in_green < mn) mn = in_green;
    if (in_blue  < mn) mn = in_blue;
    dd = mx - mn;
    sm = {1'b0, mx} + {1'b0, mn};
    den_c = (sm <= 9'd255) ? {2'b0, sm} : (11'd510 - {2'b0, sm});
    if (mx == in_red)
      num_c = (in_green >= in_blue) ? {3'b0, in_green - in_blue}
                                    : (11'd6 * {3'b0, dd} - {3'b0, in_blue - in_green});
    else if (mx == in_green)
      num_c = 11'd2 * {3'b0, dd} + {3'b0, in_blue} - {3'b0, in_red};
    else
      num_c = 11'd4 * {3'b0, dd} + {3'b0, in_red} - {3'b0, in_green};
  end

  logic        s1_valid, s1_d0;
  logic [7:0]  s1_alpha;
  logic [10:0] s1_sm, s1_den, s1_num, s1_sixd, s1_d;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else     s1_valid <= start && !busy;
    s1_d0    <= (dd == 8'd0);
    s1_alpha <= in_alpha;
    s1_sm    <= {2'b0, sm};
    s1_den   <= den_c;
    s1_num   <= num_c;
    s1_sixd  <= 11'd6 * {3'b0, dd};
    s1_d     <= {3'b0, dd};
  end

  // dividers: hue, saturation
  logic [W-1:0] hq, sq;
  logic         h_nz, s_nz;

  pha_div #(.FRAC_BITS(FRAC_BITS)) u_div_hue (
    .clk(clk), .num(s1_num), .den(s1_sixd), .quo(hq), .rem_nz(h_nz));
  pha_div #(.FRAC_BITS(FRAC_BITS)) u_div_sd (
    .clk(clk), .num(s1_d), .den(s1_den), .quo(sq), .rem_nz(s_nz));

  // lightness: sm = 255a + b, so sm / 510 = a / 2 + b / 510, and b / 255
  // is the byte b repeated in binary; ceiling adds one when b is nonzero
  logic [1:0]   lum_a;
  logic [7:0]   lum_b;
  logic [31:0]  lum_rep;
  logic [W-1:0] lum_c;

  always_comb begin
    if (s1_sm >= 11'd510) begin
      lum_a = 2'd2;
      lum_b = 8'(s1_sm - 11'd510);
    end else if (s1_sm >= 11'd255) begin
      lum_a = 2'd1;
      lum_b = 8'(s1_sm - 11'd255);
    end else begin
      lum_a = 2'd0;
      lum_b = s1_sm[7:0];
    end
    lum_rep = {4{lum_b}};
    lum_c   = (W'(lum_a) << (FRAC_BITS-1)) + W'(lum_rep[31 -: FRAC_BITS-1])
              + W'(lum_b != 8'd0);
  end

  // sideband along the dividers
  logic         sb_valid [0:FRAC_BITS];
  logic         sb_d0    [0:FRAC_BITS];
  logic [7:0]   sb_alpha [0:FRAC_BITS];
  logic [W-1:0] sb_lum   [0:FRAC_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k <= FRAC_BITS; k++) sb_valid[k] <= 1'b0;
    end else begin
      sb_valid[0] <= s1_valid;
      for (int k = 1; k <= FRAC_BITS; k++) sb_valid[k] <= sb_valid[k-1];
    end
    sb_d0[0]    <= s1_d0;
    sb_alpha[0] <= s1_alpha;
    sb_lum[0]   <= lum_c;
    for (int k = 1; k <= FRAC_BITS; k++) begin
      sb_d0[k]    <= sb_d0[k-1];
      sb_alpha[k] <= sb_alpha[k-1];
      sb_lum[k]   <= sb_lum[k-1];
    end
  end

  // P1: hue offset, ceiling rounding
  logic [FRAC_BITS+15:0] off_ext;
  logic [FRAC_BITS-1:0]  off_s, hue_c;
  assign off_ext = {hue_offset, {FRAC_BITS{1'b0}}};
  assign off_s   = off_ext[FRAC_BITS+15:16];
  assign hue_c   = (sb_d0[FRAC_BITS] ? '0 : hq[FRAC_BITS-1:0]) + off_s;

  logic                 p1_valid;
  logic [7:0]           p1_alpha;
  logic [FRAC_BITS-1:0] p1_hue;
  logic [W-1:0]         p1_sat, p1_lum;

  always_ff @(posedge clk) begin
    if (rst) p1_valid <= 1'b0;
    else     p1_valid <= sb_valid[FRAC_BITS];
    p1_alpha <= sb_alpha[FRAC_BITS];
    p1_hue   <= hue_c;
    p1_sat   <= sb_d0[FRAC_BITS] ? '0 : (sq + W'(s_nz));
    p1_lum   <= sb_lum[FRAC_BITS];
  end

  // P2: gain products
  logic                 p2_valid;
  logic [7:0]           p2_alpha;
  logic [FRAC_BITS-1:0] p2_hue;
  logic [W+15:0]        p2_sprod, p2_lprod;

  always_ff @(posedge clk) begin
    if (rst) p2_valid <= 1'b0;
    else     p2_valid <= p1_valid;
    p2_alpha <= p1_alpha;
    p2_hue   <= p1_hue;
    p2_sprod <= (W+16)'(p1_sat) * (W+16)'(sat_gain);
    p2_lprod <= (W+16)'(p1_lum) * (W+16)'(lum_gain);
  end

  // P3: drop Q8.8 fraction, clamp to one
  logic [W+7:0] s_sh, l_sh;
  assign s_sh = p2_sprod[W+15:8];
  assign l_sh = p2_lprod[W+15:8];

  logic                 p3_valid;
  logic [7:0]           p3_alpha;
  logic [FRAC_BITS-1:0] p3_hue;
  logic [W-1:0]         p3_sat, p3_lum;

  always_ff @(posedge clk) begin
    if (rst) p3_valid <= 1'b0;
    else     p3_valid <= p2_valid;
    p3_alpha <= p2_alpha;
    p3_hue   <= p2_hue;
    p3_sat   <= (s_sh > (W+8)'(ONE)) ? ONE : s_sh[W-1:0];
    p3_lum   <= (l_sh > (W+8)'(ONE)) ? ONE : l_sh[W-1:0];
  end

  // P4: L * S product
  logic                 p4_valid, p4_lhalf;
  logic [7:0]           p4_alpha;
  logic [FRAC_BITS-1:0] p4_hue;
  logic [W-1:0]         p4_sat, p4_lum;
  logic [2*W-1:0]       p4_ls;

  always_ff @(posedge clk) begin
    if (rst) p4_valid <= 1'b0;
    else     p4_valid <= p3_valid;
    p4_alpha <= p3_alpha;
    p4_hue   <= p3_hue;
    p4_sat   <= p3_sat;
    p4_lum   <= p3_lum;
    p4_lhalf <= {p3_lum, 1'b0} < {1'b0, ONE};
    p4_ls    <= (2*W)'(p3_lum) * (2*W)'(p3_sat);
  end

  // P5: p and q, hue segment and ramp factor per channel
  logic signed [SW-1:0] ls_s, l_s, s_s, qs, ps, one_s;
  logic [W-1:0]         p_c, q_c;

  always_comb begin
    one_s = SW'(ONE);
    ls_s  = SW'(p4_ls[FRAC_BITS+W-1:FRAC_BITS]);
    l_s   = SW'(p4_lum);
    s_s   = SW'(p4_sat);
    qs    = p4_lhalf ? (l_s + ls_s) : (l_s + s_s - ls_s);
    ps    = (l_s <<< 1) - qs;
    if (ps < 0)     ps = '0;
    if (ps > one_s) ps = one_s;
    if (qs < ps)    qs = ps;
    if (qs > one_s) qs = one_s;
    p_c = ps[W-1:0];
    q_c = qs[W-1:0];
  end

  logic [FRAC_BITS-1:0] t_ch [0:2];
  assign t_ch[0] = p4_hue + THIRD[FRAC_BITS-1:0];
  assign t_ch[1] = p4_hue;
  assign t_ch[2] = p4_hue - THIRD[FRAC_BITS-1:0];

  logic                 p5_valid, p5_sz;
  logic [7:0]           p5_alpha;
  logic [W-1:0]         p5_p, p5_q, p5_qmp, p5_lum;
  pha_pkg::seg_t        p5_seg [0:2];
  logic [W-1:0]         p5_fac [0:2];

  for (genvar c = 0; c < 3; c++) begin : g_seg
    logic [FRAC_BITS+2:0] six_t, three_t;
    pha_pkg::seg_t        seg_c;
    logic [W-1:0]         fac_c;
    always_comb begin
      six_t   = (FRAC_BITS+3)'(t_ch[c]) * (FRAC_BITS+3)'(6);
      three_t = (FRAC_BITS+3)'(t_ch[c]) * (FRAC_BITS+3)'(3);
      fac_c   = '0;
      if (six_t < (FRAC_BITS+3)'(ONE)) begin
        seg_c = pha_pkg::SEG_RISE;
        fac_c = six_t[W-1:0];
      end else if (!t_ch[c][FRAC_BITS-1]) begin
        seg_c = pha_pkg::SEG_HIGH;
      end else if (three_t < ((FRAC_BITS+3)'(ONE) << 1)) begin
        seg_c = pha_pkg::SEG_FALL;
        fac_c = W'(((FRAC_BITS+3)'(ONE) << 2) - six_t);
      end else begin
        seg_c = pha_pkg::SEG_LOW;
      end
    end
    always_ff @(posedge clk) begin
      p5_seg[c] <= seg_c;
      p5_fac[c] <= fac_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) p5_valid <= 1'b0;
    else     p5_valid <= p4_valid;
    p5_alpha <= p4_alpha;
    p5_sz    <= (p4_sat == '0);
    p5_lum   <= p4_lum;
    p5_p     <= p_c;
    p5_q     <= q_c;
    p5_qmp   <= q_c - p_c;
  end

  // P6: ramp products
  logic                 p6_valid, p6_sz;
  logic [7:0]           p6_alpha;
  logic [W-1:0]         p6_p, p6_q, p6_lum;
  pha_pkg::seg_t        p6_seg  [0:2];
  logic [2*W-1:0]       p6_prod [0:2];

  always_ff @(posedge clk) begin
    if (rst) p6_valid <= 1'b0;
    else     p6_valid <= p5_valid;
    p6_alpha <= p5_alpha;
    p6_sz    <= p5_sz;
    p6_lum   <= p5_lum;
    p6_p     <= p5_p;
    p6_q     <= p5_q;
    for (int c = 0; c < 3; c++) begin
      p6_seg[c]  <= p5_seg[c];
      p6_prod[c] <= (2*W)'(p5_qmp) * (2*W)'(p5_fac[c]);
    end
  end

  // P7: channel value, gray when saturation is zero
  logic                 p7_valid;
  logic [7:0]           p7_alpha;
  logic [W-1:0]         p7_v [0:2];

  for (genvar c = 0; c < 3; c++) begin : g_val
    logic [W-1:0] v_c;
    always_comb begin
      case (p6_seg[c])
        pha_pkg::SEG_RISE,
        pha_pkg::SEG_FALL: v_c = p6_p + p6_prod[c][FRAC_BITS+W-1:FRAC_BITS];
        pha_pkg::SEG_HIGH: v_c = p6_q;
        default:           v_c = p6_p;
      endcase
      if (p6_sz) v_c = p6_lum;
    end
    always_ff @(posedge clk) begin
      p7_v[c] <= v_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) p7_valid <= 1'b0;
    else     p7_valid <= p6_valid;
    p7_alpha <= p6_alpha;
  end

  // P8: scale by 255
  logic         p8_valid;
  logic [7:0]   p8_alpha;
  logic [W+7:0] p8_x [0:2];

  always_ff @(posedge clk) begin
    if (rst) p8_valid <= 1'b0;
    else     p8_valid <= p7_valid;
    p8_alpha <= p7_alpha;
    for (int c = 0; c < 3; c++) p8_x[c] <= (W+8)'(p7_v[c]) * (W+8)'(255);
  end

  // P9: to bytes, output register
  logic [8:0] byte_c [0:2];
  logic [7:0] byte_s [0:2];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      byte_c[c] = p8_x[c][FRAC_BITS+8:FRAC_BITS];
      byte_s[c] = byte_c[c][8] ? 8'd255 : byte_c[c][7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= p8_valid;
    out_red   <= byte_s[0];
    out_green <= byte_s[1];
    out_blue  <= byte_s[2];
    out_alpha <= p8_alpha;
  end

endmodule

### src/pha_check.sv
// ----------------------------------------------------------------------------
// pha_check
// Port-level checks for pixel_hsl_adjust, bound to the top level.
// ----------------------------------------------------------------------------
module pha_check #(
  parameter int FRAC_BITS = 16
) (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic [7:0] in_alpha,
  input logic [7:0] out_alpha
);

  localparam int LAT = FRAC_BITS + 11;

  // every request is taken
  a_never_busy: assert property (@(posedge clk) disable iff (rst) !busy)
    else $error("busy raised");

  // no result without an earlier request
  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy && !rst, LAT))
    else $error("result without request");

  // every request yields a result
  a_no_loss: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##LAT done)
    else $error("request lost");

  // alpha travels unchanged with its request
  a_alpha: assert property (@(posedge clk) disable iff (rst)
    done |-> (out_alpha == $past(in_alpha, LAT)))
    else $error("alpha mismatch");

endmodule

bind pixel_hsl_adjust pha_check #(.FRAC_BITS(FRAC_BITS)) u_pha_check (
  .clk(clk), .rst(rst), .start(start), .busy(busy), .done(done),
  .in_alpha(in_alpha), .out_alpha(out_alpha));
